// ----- rtl/core/asq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the seven-to-six squeeze block.
// No dependencies; imported by asq_squeeze and adaptive_seven_to_six_squeeze.
package asq_pkg;

  localparam int NUM_PENS  = 7;
  localparam int NUM_PIX   = 6;
  localparam int NUM_PAIRS = 6;
  localparam int PAL_WORDS = 4;

  localparam int PEN_W   = 4;
  localparam int PIX_W   = 16;
  localparam int DROP_W  = 3;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PAL_WORD_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_WORD_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_WORD_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_WORD_3 = 2'd3;

  // dropped_pen code for the averaged-middle path
  localparam logic [DROP_W-1:0] BLEND_CODE = 3'd6;

  // Pair search order, highest priority first (middle pairs first)
  localparam logic [NUM_PAIRS-1:0][DROP_W-1:0] PAIR_ORDER =
    {3'd0, 3'd5, 3'd1, 3'd4, 3'd2, 3'd3};

  typedef logic [PAL_WORDS-1:0][CFG_W-1:0] pal_t;
  typedef logic [NUM_PENS-1:0][PEN_W-1:0]  pen_arr_t;

  typedef struct packed {
    logic [PEN_W-1:0] pen_0;
    logic [PEN_W-1:0] pen_1;
    logic [PEN_W-1:0] pen_2;
    logic [PEN_W-1:0] pen_3;
    logic [PEN_W-1:0] pen_4;
    logic [PEN_W-1:0] pen_5;
    logic [PEN_W-1:0] pen_6;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_0;
    logic [PIX_W-1:0]  pixel_1;
    logic [PIX_W-1:0]  pixel_2;
    logic [PIX_W-1:0]  pixel_3;
    logic [PIX_W-1:0]  pixel_4;
    logic [PIX_W-1:0]  pixel_5;
    logic [DROP_W-1:0] dropped_pen;
  } out_t;

  function automatic pen_arr_t pens_of(input in_t item);
    pen_arr_t p;
    p[0] = item.pen_0;
    p[1] = item.pen_1;
    p[2] = item.pen_2;
    p[3] = item.pen_3;
    p[4] = item.pen_4;
    p[5] = item.pen_5;
    p[6] = item.pen_6;
    return p;
  endfunction

  // Equality flag of each neighbor pair (pen k, pen k+1)
  function automatic logic [NUM_PAIRS-1:0] pair_eq(input pen_arr_t p);
    logic [NUM_PAIRS-1:0] eq;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      eq[k] = (p[k] == p[k+1]);
    end
    return eq;
  endfunction

  function automatic logic [PIX_W-1:0] pen_colour(input pal_t pal, input logic [PEN_W-1:0] pen);
    return pal[pen[3:2]][{pen[1:0], 4'h0} +: PIX_W];
  endfunction

  function automatic logic [PIX_W-1:0] byte_swap(input logic [PIX_W-1:0] c);
    return {c[7:0], c[15:8]};
  endfunction

  // Per-channel truncated average of two RGB565 colors
  function automatic logic [PIX_W-1:0] blend_colours(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b);
    logic [5:0] r;
    logic [6:0] g;
    logic [5:0] bl;
    r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
    g  = {1'b0, a[10:5]}  + {1'b0, b[10:5]};
    bl = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
    return {r[5:1], g[6:1], bl[5:1]};
  endfunction

endpackage

// ----- rtl/core/asq_squeeze.sv -----
`timescale 1ns / 1ps
// Combinational squeeze of one seven-pen row into six byte-swapped pixels.
// Depends on asq_pkg.
module asq_squeeze import asq_pkg::*; (
  input  in_t  item,
  input  pal_t pal,
  output out_t result
);

  pen_arr_t             pens;
  logic [NUM_PAIRS-1:0] eq;
  logic [DROP_W-1:0]    drop;
  logic [NUM_PIX-1:0][PIX_W-1:0] pix;

  assign pens = pens_of(item);
  assign eq   = pair_eq(pens);

  // Walk lowest priority first so the highest-priority hit wins
  always_comb begin
    drop = BLEND_CODE;
    for (int i = NUM_PAIRS - 1; i >= 0; i--) begin
      if (eq[PAIR_ORDER[i]]) begin
        drop = PAIR_ORDER[i];
      end
    end
  end

  // Pixel k takes pen k left of the dropped pen, pen k+1 from there on.
  // Blend path behaves like a drop at 3, with pixel 3 replaced by the average.
  always_comb begin
    logic [DROP_W-1:0] cut;
    logic [DROP_W-1:0] src;
    cut = (drop == BLEND_CODE) ? 3'd3 : drop;
    for (int k = 0; k < NUM_PIX; k++) begin
      src    = (3'(k) < cut) ? 3'(k) : 3'(k + 1);
      pix[k] = pen_colour(pal, pens[src]);
    end
    if (drop == BLEND_CODE) begin
      pix[3] = blend_colours(pen_colour(pal, pens[3]), pen_colour(pal, pens[4]));
    end
  end

  always_comb begin
    result.pixel_0     = byte_swap(pix[0]);
    result.pixel_1     = byte_swap(pix[1]);
    result.pixel_2     = byte_swap(pix[2]);
    result.pixel_3     = byte_swap(pix[3]);
    result.pixel_4     = byte_swap(pix[4]);
    result.pixel_5     = byte_swap(pix[5]);
    result.dropped_pen = drop;
  end

endmodule

// ----- rtl/core/adaptive_seven_to_six_squeeze.sv -----
`timescale 1ns / 1ps
// Top level of the seven-to-six pen squeeze: input register, squeeze logic, result register.
// Depends on asq_pkg and asq_squeeze.
//
// Usage
//   Input: one row of seven 4-bit pens on in_data, transferred at a clock edge with
//   start high and busy low. busy is always low: a new row can be transferred every cycle.
//   Result: six byte-swapped RGB565 pixels plus the dropped pen index on out_data,
//   shown for exactly one cycle with out_strobe high. The receiver has no way to stall,
//   so every result must be taken in its strobe cycle.
//   A row passes from the start transfer through the input register, then the result
//   register, to out_strobe. Throughput: one row per clock, limited by nothing but the
//   two register stages; rows do not interact.
//   Configuration: cfg_we writes cfg_wdata into palette word cfg_index (four words of
//   four RGB565 colors, pen 0 in the low 16 bits of word 0). Write only while no row
//   is in flight; the palette is read directly by the squeeze logic.
//   Reset (rst_n low, synchronous): palette cleared to zero, in-flight rows discarded,
//   out_strobe low.
module adaptive_seven_to_six_squeeze import asq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_strobe,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  pal_t pal_r, pal_nxt;
  in_t  in_r;
  logic in_v_r;
  out_t out_r, out_nxt;
  logic out_v_r;

  // No internal backlog: always ready for the next row
  assign busy = 1'b0;

  // Palette register file
  always_comb begin
    pal_nxt = pal_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PAL_WORD_0: pal_nxt[0] = cfg_wdata;
        REG_PAL_WORD_1: pal_nxt[1] = cfg_wdata;
        REG_PAL_WORD_2: pal_nxt[2] = cfg_wdata;
        REG_PAL_WORD_3: pal_nxt[3] = cfg_wdata;
        default:        pal_nxt    = pal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r <= '0;
    end else begin
      pal_r <= pal_nxt;
    end
  end

  // Stage 1: capture the transferred row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  // Stage 2: squeeze and register the result
  asq_squeeze u_squeeze (
    .item   (in_r),
    .pal    (pal_r),
    .result (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_v_r;
  assign out_data   = out_r;

  // Checks
  logic [NUM_PAIRS-1:0] stage1_eq;
  assign stage1_eq = pair_eq(pens_of(in_r));

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("result strobe missing two cycles after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_v_r))
    else $error("result strobe without a row in stage 1");

  a_drop_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.dropped_pen <= BLEND_CODE))
    else $error("dropped_pen out of range");

  a_blend_iff_no_pair: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |=> ((out_data.dropped_pen == BLEND_CODE) == ($past(stage1_eq) == '0)))
    else $error("blend path disagrees with pair equality");

endmodule

// ----- tb/sv/adaptive_seven_to_six_squeeze_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for adaptive_seven_to_six_squeeze: predicts each squeezed row
// from a local palette copy and checks every strobed result. Depends on asq_pkg.
module adaptive_seven_to_six_squeeze_tb;
  import asq_pkg::*;

  // Pair search order, middle pairs first
  localparam int SEARCH_ORDER [NUM_PAIRS] = '{3, 2, 4, 1, 5, 0};
  // Cycles with no transfer of any kind before the run is declared hung.
  // Sender gaps are capped at MAX_GAP, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 60;
  // Pipeline is two register stages deep; settle a little past that.
  localparam int SETTLE_CYCLES  = 4;
  localparam int ROWS_PER_PHASE = 213;

  localparam logic [CFG_IDX_W-1:0] PAL_REGS [PAL_WORDS] =
    '{REG_PAL_WORD_0, REG_PAL_WORD_1, REG_PAL_WORD_2, REG_PAL_WORD_3};

  // ---------------------------------------------------------------------------
  // Expected-row ledger: keeps its own palette copy, computes the squeezed row
  // for every accepted input and checks results in order.
  // ---------------------------------------------------------------------------
  class squeeze_ledger;
    logic [CFG_W-1:0] palette [PAL_WORDS];
    out_t             rows_due [$];
    int unsigned      mismatches;

    function new();
      foreach (palette[i]) palette[i] = '0;
      mismatches = 0;
    endfunction

    function void write_palette(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      palette[idx] = val;
    endfunction

    function logic [PIX_W-1:0] colour_of(logic [PEN_W-1:0] pen);
      logic [CFG_W-1:0] w;
      w = palette[pen[3:2]] >> (16 * pen[1:0]);
      return w[PIX_W-1:0];
    endfunction

    function logic [PIX_W-1:0] swapped(logic [PIX_W-1:0] c);
      return {c[7:0], c[15:8]};
    endfunction

    // Channel-wise average, rounding down
    function logic [PIX_W-1:0] mid_blend(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      int r;
      int g;
      int bl;
      r  = (int'(a[15:11]) + int'(b[15:11])) / 2;
      g  = (int'(a[10:5])  + int'(b[10:5]))  / 2;
      bl = (int'(a[4:0])   + int'(b[4:0]))   / 2;
      return {r[4:0], g[5:0], bl[4:0]};
    endfunction

    function out_t squeeze_row(in_t row);
      logic [PEN_W-1:0]  p   [NUM_PENS];
      logic [PIX_W-1:0]  pix [NUM_PIX];
      logic [DROP_W-1:0] drop;
      int                src;
      out_t              res;
      p[0] = row.pen_0; p[1] = row.pen_1; p[2] = row.pen_2; p[3] = row.pen_3;
      p[4] = row.pen_4; p[5] = row.pen_5; p[6] = row.pen_6;
      drop = BLEND_CODE;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        if (drop == BLEND_CODE && p[SEARCH_ORDER[k]] == p[SEARCH_ORDER[k] + 1])
          drop = DROP_W'(SEARCH_ORDER[k]);
      end
      if (drop == BLEND_CODE) begin
        pix[0] = colour_of(p[0]);
        pix[1] = colour_of(p[1]);
        pix[2] = colour_of(p[2]);
        pix[3] = mid_blend(colour_of(p[3]), colour_of(p[4]));
        pix[4] = colour_of(p[5]);
        pix[5] = colour_of(p[6]);
      end else begin
        src = 0;
        for (int k = 0; k < NUM_PIX; k++) begin
          if (src == int'(drop)) src++;
          pix[k] = colour_of(p[src]);
          src++;
        end
      end
      res.pixel_0     = swapped(pix[0]);
      res.pixel_1     = swapped(pix[1]);
      res.pixel_2     = swapped(pix[2]);
      res.pixel_3     = swapped(pix[3]);
      res.pixel_4     = swapped(pix[4]);
      res.pixel_5     = swapped(pix[5]);
      res.dropped_pen = drop;
      return res;
    endfunction

    function void note_row(in_t row);
      rows_due.push_back(squeeze_row(row));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task field_check(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_row(out_t got);
      out_t want;
      if (rows_due.size() == 0) begin
        report("result strobed with no row in flight");
        return;
      end
      want = rows_due.pop_front();
      field_check("pixel_0", got.pixel_0, want.pixel_0);
      field_check("pixel_1", got.pixel_1, want.pixel_1);
      field_check("pixel_2", got.pixel_2, want.pixel_2);
      field_check("pixel_3", got.pixel_3, want.pixel_3);
      field_check("pixel_4", got.pixel_4, want.pixel_4);
      field_check("pixel_5", got.pixel_5, want.pixel_5);
      field_check("dropped_pen", PIX_W'(got.dropped_pen), PIX_W'(want.dropped_pen));
    endtask

    function int pending();
      return rows_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_t                  in_data;
  logic                 out_strobe;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  squeeze_ledger ledger;
  int            quiet_cycles;

  adaptive_seven_to_six_squeeze dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block's own
  // nonblocking updates land, so each transfer is seen exactly as the block
  // sees it. Also runs the hang watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) ledger.write_palette(cfg_index, cfg_wdata);
      if (start && !busy) ledger.note_row(in_data);
      if (out_strobe) ledger.check_row(out_data);
      if ((start && !busy) || out_strobe || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic in_t row_of(int a, int b, int c, int d, int e, int f, int g);
    in_t r;
    r.pen_0 = PEN_W'(a); r.pen_1 = PEN_W'(b); r.pen_2 = PEN_W'(c); r.pen_3 = PEN_W'(d);
    r.pen_4 = PEN_W'(e); r.pen_5 = PEN_W'(f); r.pen_6 = PEN_W'(g);
    return r;
  endfunction

  // Random row, shaped so equal pairs show up often:
  //   full random (mostly blend), narrow pen range (runs of equal pens),
  //   or full random with one chosen pair forced equal.
  function automatic in_t random_row();
    int p [NUM_PENS];
    int base;
    int k;
    int mode;
    mode = $urandom_range(2);
    base = $urandom_range(15);
    foreach (p[i]) begin
      if (mode == 1) p[i] = (base + $urandom_range(2)) % 16;
      else           p[i] = $urandom_range(15);
    end
    if (mode == 2) begin
      k = $urandom_range(NUM_PAIRS - 1);
      p[k + 1] = p[k];
    end
    return row_of(p[0], p[1], p[2], p[3], p[4], p[5], p[6]);
  endfunction

  function automatic logic [CFG_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // One row transfer. A random gap (start low, junk on the data bus) may come
  // first; start then stays high so back-to-back rows go every cycle.
  task automatic send_row(in_t row, int idle_pct);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start   <= 1'b0;
      in_data <= in_t'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= row;
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every row in flight has come back, then let
  // the pipeline settle. Needed before any palette write.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four palette words on consecutive cycles.
  task automatic load_palette(logic [CFG_W-1:0] w0, logic [CFG_W-1:0] w1,
                              logic [CFG_W-1:0] w2, logic [CFG_W-1:0] w3);
    logic [CFG_W-1:0] words [PAL_WORDS];
    words = '{w0, w1, w2, w3};
    for (int i = 0; i < PAL_WORDS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= PAL_REGS[i];
      cfg_wdata <= words[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int idle_pct);
    for (int n = 0; n < ROWS_PER_PHASE; n++) send_row(random_row(), idle_pct);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    ledger       = new();
    quiet_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_PAL_WORD_0;
    cfg_wdata    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Palette is all zero out of reset
    send_row(row_of(0, 1, 2, 3, 4, 5, 6), 0);
    send_row(row_of(9, 9, 9, 9, 9, 9, 9), 0);
    drain();

    // Channel extremes: full-scale and empty red, green, blue in various pens
    load_palette({16'h07E0, 16'hF81F, 16'hFFFF, 16'h0000},
                 {16'hFFE0, 16'hF81F, 16'h07FF, 16'h001F},
                 {16'h0841, 16'hF7BE, 16'h07E0, 16'hF800},
                 {16'hFFFF, 16'h001F, 16'h8410, 16'h7BEF});

    // Directed rows
    send_row(row_of(0, 0, 0, 0, 0, 0, 0), 0);         // all pens equal: middle pair wins
    send_row(row_of(15, 15, 15, 15, 15, 15, 15), 0);
    send_row(row_of(0, 1, 2, 3, 4, 5, 6), 0);         // no equal pair: blend
    send_row(row_of(15, 14, 13, 12, 11, 10, 9), 0);
    send_row(row_of(1, 2, 3, 0, 1, 2, 3), 0);         // blend full-scale with empty
    send_row(row_of(2, 3, 4, 5, 6, 7, 8), 0);         // blend green-blue with red-blue
    send_row(row_of(10, 5, 10, 5, 10, 5, 10), 0);     // alternating bit patterns
    send_row(row_of(5, 10, 5, 10, 5, 10, 5), 0);
    // Exactly one equal pair, each position
    send_row(row_of(7, 7, 1, 2, 3, 4, 5), 0);
    send_row(row_of(1, 7, 7, 2, 3, 4, 5), 0);
    send_row(row_of(1, 2, 7, 7, 3, 4, 5), 0);
    send_row(row_of(1, 2, 3, 7, 7, 4, 5), 0);
    send_row(row_of(1, 2, 3, 4, 7, 7, 5), 0);
    send_row(row_of(1, 2, 3, 4, 5, 7, 7), 0);
    // Several equal pairs: only the highest-priority one drops a pen
    send_row(row_of(0, 1, 2, 2, 3, 3, 4), 0);         // pairs 2 and 4
    send_row(row_of(7, 7, 7, 1, 2, 3, 4), 0);         // pairs 0 and 1
    send_row(row_of(1, 1, 2, 3, 4, 5, 5), 0);         // pairs 0 and 5
    send_row(row_of(3, 3, 4, 4, 5, 6, 6), 0);         // pairs 0, 2 and 5
    send_row(row_of(8, 9, 9, 9, 9, 0, 0), 0);         // pairs 1, 2, 3, 5
    drain();

    // Random phases over several palettes and sender idle rates
    load_palette(random_word(), random_word(), random_word(), random_word());
    random_phase(0);
    load_palette('1, '1, '1, '1);
    random_phase(73);
    load_palette({4{16'h5555}}, {4{16'hAAAA}}, {4{16'hAAAA}}, {4{16'h5555}});
    random_phase(0);
    load_palette('0, '0, '0, '0);
    random_phase(21);
    load_palette(random_word(), random_word(), random_word(), random_word());
    random_phase(73);
    load_palette(random_word(), '1, random_word(), '0);
    random_phase(0);

    drain();
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
